/* hw/rtl/egbe_pkg.sv */
// Shared constants and types for the Elias gamma byte encoder.
// No dependencies; used by egbe_form and elias_gamma_byte_encoder.
`timescale 1ns / 1ps

package egbe_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int LOG_W       = $clog2(VALUE_WIDTH);
    localparam int CODE_W      = 2 * VALUE_WIDTH;
    localparam int SHIFT_W     = $clog2(CODE_W);
    localparam int BYTE_W      = 8;
    localparam int MAX_BYTES   = CODE_W / BYTE_W;
    localparam int CNT_W       = $clog2(MAX_BYTES + 1);

    // One value's code, left-aligned, with its byte count.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  nbytes;
        logic              zero_err;
    } egbe_code_t;

endpackage

/* hw/rtl/egbe_form.sv */
// Combinational formation of the left-aligned gamma code for one value.
// Depends on egbe_pkg.
`timescale 1ns / 1ps

module egbe_form
(
    input  logic [egbe_pkg::VALUE_WIDTH-1:0] value,
    output egbe_pkg::egbe_code_t             code
);

    logic [egbe_pkg::LOG_W-1:0]       lg;
    logic [egbe_pkg::VALUE_WIDTH-1:0] low_bits;
    logic [egbe_pkg::SHIFT_W-1:0]     shamt;
    logic [egbe_pkg::CODE_W-1:0]      ones;
    logic [egbe_pkg::LOG_W:0]         len_sum;

    // Position of the leading one; zero when only bit 0 (or nothing) is set.
    always_comb
    begin
        lg = '0;
        for (int i = 1; i < egbe_pkg::VALUE_WIDTH; i++)
        begin
            if (value[i])
            begin
                lg = egbe_pkg::LOG_W'(i);
            end
        end
    end

    assign low_bits = value & ~(egbe_pkg::VALUE_WIDTH'(1) << lg);
    // The low bits start just below the unary prefix and its zero separator.
    assign shamt    = egbe_pkg::SHIFT_W'(egbe_pkg::CODE_W - 1)
                      - egbe_pkg::SHIFT_W'({lg, 1'b0});
    assign ones     = ~({egbe_pkg::CODE_W{1'b1}} >> lg);
    // Bytes needed for 2L+1 bits is (L+4)/4 rounded down.
    assign len_sum  = {1'b0, lg} + (egbe_pkg::LOG_W + 1)'(4);

    always_comb
    begin
        if (value == '0)
        begin
            code.code     = '0;
            code.nbytes   = egbe_pkg::CNT_W'(1);
            code.zero_err = 1'b1;
        end
        else
        begin
            code.code     = ones
                            | ({{egbe_pkg::VALUE_WIDTH{1'b0}}, low_bits} << shamt);
            code.nbytes   = egbe_pkg::CNT_W'(len_sum >> 2);
            code.zero_err = 1'b0;
        end
    end

endmodule

/* hw/rtl/elias_gamma_byte_encoder.sv */
// Elias gamma byte encoder: input register, code formation and byte shifter.
// The first byte beat is offered from the shifter after the value has passed the input register.
// One byte beat per cycle while out_ready is high; a value gives (floor(log2(v))+4)/4 bytes, 1 to 8
// (one for zero), set by the byte shifter, and values follow one another with no gap.
// rst_n is asynchronous and active low; it empties both stages.
// Depends on egbe_pkg and egbe_form.
`timescale 1ns / 1ps

module elias_gamma_byte_encoder
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [egbe_pkg::VALUE_WIDTH-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [egbe_pkg::BYTE_W-1:0]      code_byte,
    output logic                             last_byte,
    output logic                             zero_error
);

    logic                             hold_valid_reg;
    logic                             hold_valid_next;
    logic [egbe_pkg::VALUE_WIDTH-1:0] value_reg;
    logic [egbe_pkg::CODE_W-1:0]      code_shift_reg;
    logic [egbe_pkg::CODE_W-1:0]      code_shift_next;
    logic [egbe_pkg::CNT_W-1:0]       bytes_left_reg;
    logic [egbe_pkg::CNT_W-1:0]       bytes_left_next;
    logic                             zero_err_reg;
    logic                             zero_err_next;
    egbe_pkg::egbe_code_t             formed;
    logic                             out_fire;
    logic                             load_shift;

    egbe_form u_form
    (
        .value (value_reg),
        .code  (formed)
    );

    assign out_valid  = (bytes_left_reg != '0);
    assign out_fire   = out_valid && out_ready;
    assign last_byte  = (bytes_left_reg == egbe_pkg::CNT_W'(1));
    assign code_byte  = code_shift_reg[egbe_pkg::CODE_W-1 -: egbe_pkg::BYTE_W];
    assign zero_error = zero_err_reg;

    // The shifter takes a new code when empty or when its last byte leaves.
    assign load_shift = !out_valid || (out_fire && last_byte);
    assign in_ready   = !hold_valid_reg || load_shift;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        code_shift_next = code_shift_reg;
        bytes_left_next = bytes_left_reg;
        zero_err_next   = zero_err_reg;
        if (in_ready)
        begin
            hold_valid_next = in_valid;
        end
        if (load_shift)
        begin
            code_shift_next = formed.code;
            zero_err_next   = formed.zero_err;
            bytes_left_next = hold_valid_reg ? formed.nbytes : '0;
        end
        else if (out_fire)
        begin
            code_shift_next = code_shift_reg << egbe_pkg::BYTE_W;
            bytes_left_next = bytes_left_reg - egbe_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            bytes_left_reg <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            value_reg <= value;
        end
        code_shift_reg <= code_shift_next;
        zero_err_reg   <= zero_err_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= egbe_pkg::CNT_W'(egbe_pkg::MAX_BYTES))
        else $error("byte count beyond the longest code");

    a_zero_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_error) |-> (last_byte && code_byte == '0))
        else $error("zero value must give a single zero byte");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !last_byte) |=> out_valid)
        else $error("code run broken before its last byte");

    a_hold_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> hold_valid_reg)
        else $error("accepted value lost from the input register");

    a_hold_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && load_shift && !(in_valid && in_ready)) |=> out_valid)
        else $error("held value not moved into the shifter");
`endif

endmodule
